// File: src/sscc_pkg.sv
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared types and constants of the six-step commutation controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sscc_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned PAT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // floor(x / 6) == (x * 43691) >> 18 for every 16-bit x
  localparam logic [16:0] DIV6_RECIP = 17'd43691;
  localparam int unsigned DIV6_SHIFT = 18;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'hFFFF;
  localparam logic [PAT_W-1:0]    PATTERN_RESET = 6'h33;

  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PER  = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_RAMP   = 2'd1,
    OP_INDEX  = 2'd2,
    OP_TARGET = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [LEVEL_W-1:0]   target_value;
  } in_word_t;

  typedef struct packed {
    logic [PAT_W-1:0]     phase_override;
    logic [LEVEL_W-1:0]   duty;
    logic                 at_target;
    logic [SECTOR_W-1:0]  sector;
    logic [1:0]           commutations;
  } out_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   low_threshold;
    logic [LEVEL_W-1:0]   high_threshold;
    logic [LEVEL_W-1:0]   slope;
    logic [PERIOD_W-1:0]  intercept;
    logic [PERIOD_W-1:0]  idle_period;
  } cfg_t;

  typedef struct packed {
    logic [PAT_W-1:0]     pattern;
    logic [SECTOR_W-1:0]  sector;
  } sector_state_t;

  function automatic logic [PAT_W-1:0] pattern_of(input logic [SECTOR_W-1:0] sec,
                                                  input logic [PAT_W-1:0] hold);
    logic [PAT_W-1:0] p;
    p = hold;
    unique case (sec)
      3'd0:    p = 6'h05;
      3'd1:    p = 6'h24;
      3'd2:    p = 6'h21;
      3'd3:    p = 6'h09;
      3'd4:    p = 6'h18;
      3'd5:    p = 6'h12;
      default: p = hold;
    endcase
    return p;
  endfunction

  // One sector advance; unused sector codes keep the pattern and restart at 0.
  function automatic sector_state_t commute(input sector_state_t s);
    sector_state_t r;
    r.pattern = pattern_of(s.sector, s.pattern);
    if (s.sector < LAST_SECTOR) begin
      r.sector = s.sector + 3'd1;
    end else begin
      r.sector = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sscc_period.sv
// ----------------------------------------------------------------------------
// sscc_period
// Commutation period from power level: idle, linear with saturation, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module sscc_period
  import sscc_pkg::*;
(
  input  wire cfg_t                cfg,
  input  wire logic [LEVEL_W-1:0]  power,
  input  wire logic [PERIOD_W-1:0] period_cur,
  output logic [PERIOD_W-1:0]      period_new
);

  logic [PERIOD_W-1:0]   prod;
  logic signed [17:0]    diff;
  logic [PERIOD_W-1:0]   lin;

  assign prod = PERIOD_W'(cfg.slope) * PERIOD_W'(power);
  assign diff = $signed({2'b00, cfg.intercept}) - $signed({2'b00, prod});

  // times four, clamped to [0, 65535]
  always_comb begin
    if (diff < 18'sd0) begin
      lin = '0;
    end else if (diff > 18'sd16383) begin
      lin = PERIOD_RESET;
    end else begin
      lin = {diff[13:0], 2'b00};
    end
  end

  always_comb begin
    if (power < cfg.low_threshold) begin
      period_new = cfg.idle_period;
    end else if (power > cfg.low_threshold && power < cfg.high_threshold) begin
      period_new = lin;
    end else begin
      period_new = period_cur;
    end
  end

endmodule

`default_nettype wire

// File: src/sscc_core.sv
// ----------------------------------------------------------------------------
// sscc_core
// Controller state and its update for one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module sscc_core
  import sscc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_word_t  item,
  input  wire cfg_t      cfg,
  output out_word_t      res
);

  localparam int unsigned EW = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
  localparam logic [EW-1:0] CNT_MASK = EW'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [LEVEL_W-1:0]     power_r, power_nxt;
  logic [LEVEL_W-1:0]     target_r, target_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [COUNT_WIDTH-1:0] fast_cnt_r, fast_cnt_nxt;
  logic [COUNT_WIDTH-1:0] slow_cnt_r, slow_cnt_nxt;
  logic [PERIOD_W-1:0]    fast_per_r, fast_per_nxt;
  logic [PERIOD_W-1:0]    slow_per_r, slow_per_nxt;
  sector_state_t          sec_r, sec_nxt;
  logic [LEVEL_W-1:0]     duty_r, duty_nxt;
  logic                   arrived_r, arrived_nxt;

  logic [PERIOD_W-1:0]    period_calc;
  logic [32:0]            div_prod;
  logic [PERIOD_W-1:0]    period_div6;
  logic                   fast_hit;
  logic                   slow_hit;
  logic [1:0]             cnt;

  sscc_period u_period (
    .cfg        (cfg),
    .power      (power_r),
    .period_cur (period_r),
    .period_new (period_calc)
  );

  assign div_prod    = 33'(period_r) * 33'(DIV6_RECIP);
  assign period_div6 = PERIOD_W'(div_prod >> DIV6_SHIFT);

  assign fast_hit = (EW'(fast_cnt_r) == (EW'(fast_per_r) & CNT_MASK));
  assign slow_hit = (EW'(slow_cnt_r) == (EW'(slow_per_r) & CNT_MASK));

  always_comb begin
    power_nxt    = power_r;
    target_nxt   = target_r;
    period_nxt   = period_r;
    fast_cnt_nxt = fast_cnt_r;
    slow_cnt_nxt = slow_cnt_r;
    fast_per_nxt = fast_per_r;
    slow_per_nxt = slow_per_r;
    sec_nxt      = sec_r;
    duty_nxt     = duty_r;
    arrived_nxt  = arrived_r;
    cnt          = 2'd0;

    unique case (item.opcode)
      OP_TICK: begin
        // fast commutation applies before the slow one
        if (fast_hit) begin
          fast_cnt_nxt = '0;
          sec_nxt      = commute(sec_nxt);
          duty_nxt     = power_r;
          cnt          = cnt + 2'd1;
        end else begin
          fast_cnt_nxt = fast_cnt_r + COUNT_WIDTH'(1);
        end
        if (slow_hit) begin
          slow_cnt_nxt = '0;
          fast_per_nxt = period_div6;
          slow_per_nxt = period_r;
          sec_nxt      = commute(sec_nxt);
          duty_nxt     = power_r;
          cnt          = cnt + 2'd1;
        end else begin
          slow_cnt_nxt = slow_cnt_r + COUNT_WIDTH'(1);
        end
      end
      OP_RAMP: begin
        period_nxt = period_calc;
        if (power_r < target_r) begin
          power_nxt   = power_r + LEVEL_W'(1);
          arrived_nxt = 1'b0;
        end else if (power_r > target_r) begin
          power_nxt   = power_r - LEVEL_W'(1);
          arrived_nxt = 1'b0;
        end else begin
          arrived_nxt = 1'b1;
        end
      end
      OP_INDEX: begin
        fast_cnt_nxt = '0;
        slow_cnt_nxt = '0;
        period_nxt   = period_calc;
        sec_nxt      = commute(sector_state_t'{pattern: sec_r.pattern, sector: '0});
        duty_nxt     = power_r;
        cnt          = 2'd1;
      end
      OP_TARGET: begin
        target_nxt = item.target_value;
      end
      default: ;
    endcase

    res.phase_override = sec_nxt.pattern;
    res.duty           = duty_nxt;
    res.at_target      = arrived_nxt;
    res.sector         = sec_nxt.sector;
    res.commutations   = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r    <= '0;
      target_r   <= '0;
      period_r   <= PERIOD_RESET;
      fast_cnt_r <= '0;
      slow_cnt_r <= '0;
      fast_per_r <= PERIOD_RESET;
      slow_per_r <= PERIOD_RESET;
      sec_r      <= '{pattern: PATTERN_RESET, sector: '0};
      duty_r     <= '0;
      arrived_r  <= 1'b0;
    end else if (step) begin
      power_r    <= power_nxt;
      target_r   <= target_nxt;
      period_r   <= period_nxt;
      fast_cnt_r <= fast_cnt_nxt;
      slow_cnt_r <= slow_cnt_nxt;
      fast_per_r <= fast_per_nxt;
      slow_per_r <= slow_per_nxt;
      sec_r      <= sec_nxt;
      duty_r     <= duty_nxt;
      arrived_r  <= arrived_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r.sector <= LAST_SECTOR)
    else $error("sector code out of range");

  a_index_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.opcode == OP_INDEX) |=> (fast_cnt_r == '0 && slow_cnt_r == '0
                                           && sec_r.sector == 3'd1))
    else $error("index pulse did not restart counters and sector");
`endif

endmodule

`default_nettype wire

// File: src/six_step_commutation_controller_top.sv
// ----------------------------------------------------------------------------
// six_step_commutation_controller_top
// Open-loop six-step motor commutation controller with word handshakes.
// ----------------------------------------------------------------------------
// One input word per clock is sustained while the output is not stalled; each
// word yields exactly one result word, presented after acceptance through the
// input register, then the result register. The rate is set by the core, whose
// state update for a word resolves period calculation, both tick counters and
// up to two sector advances together. A stalled result stays in the output
// register while the next word is held in the input register. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata; indexes past the
// last register are ignored.
`default_nettype none

module six_step_commutation_controller_top
  import sscc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_word_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  cfg_t      cfg_r;
  out_word_t core_res;
  logic      advance;
  logic      in_take;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold  <= 8'd50;
      cfg_r.high_threshold <= 8'd231;
      cfg_r.slope          <= 8'd83;
      cfg_r.intercept      <= 16'd20436;
      cfg_r.idle_period    <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_THR:   cfg_r.low_threshold  <= cfg_wdata[LEVEL_W-1:0];
        CFG_HIGH_THR:  cfg_r.high_threshold <= cfg_wdata[LEVEL_W-1:0];
        CFG_SLOPE:     cfg_r.slope          <= cfg_wdata[LEVEL_W-1:0];
        CFG_INTERCEPT: cfg_r.intercept      <= cfg_wdata;
        CFG_IDLE_PER:  cfg_r.idle_period    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= core_res;
    end
  end

  sscc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_word_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed word did not reach the result register");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && out_stall) |=> (in_vld_r && $stable(in_word_r)))
    else $error("pending input word lost while output stalled");

  a_commutation_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_word_r.commutations != 2'd3))
    else $error("commutation count out of range");
`endif

endmodule

`default_nettype wire
